>>> src/mste_pkg.sv
// Package of types, constants and tables shared by the matrix stack transform engine.
`default_nettype none
package mste_pkg;

	// Command codes carried in the mode field.
	typedef enum logic [2:0] {
		MODE_IDENTITY = 3'd0,
		MODE_TRANSLATE = 3'd1,
		MODE_ROTATE_Y = 3'd2,
		MODE_PUSH = 3'd3,
		MODE_POP = 3'd4,
		MODE_WRITE_CUR = 3'd5,
		MODE_WRITE_OPD = 3'd6,
		MODE_MULTIPLY = 3'd7
	} mode_t;

	// Result status codes.
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RANGE,
		ST_RAD,
		ST_CORDIC,
		ST_TRIG,
		ST_MAC,
		ST_ROUND,
		ST_PUSH,
		ST_POP_RD,
		ST_POP_WR,
		ST_EMIT,
		ST_ERROR
	} state_t;

	localparam int CORDIC_STEPS = 24;
	localparam logic signed [27:0] DEG90 = 28'sd5898240;
	localparam logic signed [27:0] DEG180 = 28'sd11796480;
	localparam logic signed [27:0] DEG360 = 28'sd23592960;
	localparam logic [24:0] RAD_PER_DEG_Q30 = 25'd18740330;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// Arctangent table in Q2.30, truncated.
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 30'h3243F6A8;
			5'd1: atan_q30 = 30'h1DAC6705;
			5'd2: atan_q30 = 30'h0FADBAFC;
			5'd3: atan_q30 = 30'h07F56EA6;
			5'd4: atan_q30 = 30'h03FEAB76;
			5'd5: atan_q30 = 30'h01FFD55B;
			5'd6: atan_q30 = 30'h00FFFAAA;
			5'd7: atan_q30 = 30'h007FFF55;
			5'd8: atan_q30 = 30'h003FFFEA;
			5'd9: atan_q30 = 30'h001FFFFD;
			5'd10: atan_q30 = 30'h000FFFFF;
			5'd11: atan_q30 = 30'h0007FFFF;
			5'd12: atan_q30 = 30'h0003FFFF;
			5'd13: atan_q30 = 30'h0001FFFF;
			5'd14: atan_q30 = 30'h0000FFFF;
			5'd15: atan_q30 = 30'h00007FFF;
			5'd16: atan_q30 = 30'h00003FFF;
			5'd17: atan_q30 = 30'h00001FFF;
			5'd18: atan_q30 = 30'h00000FFF;
			5'd19: atan_q30 = 30'h000007FF;
			5'd20: atan_q30 = 30'h000003FF;
			5'd21: atan_q30 = 30'h000001FF;
			5'd22: atan_q30 = 30'h000000FF;
			5'd23: atan_q30 = 30'h0000007F;
			default: atan_q30 = 30'h0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> src/mste_cordic.sv
// Iterative CORDIC rotation unit producing sine and cosine in Q2.30.
`default_nettype none
module mste_cordic
	import mste_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] angle_q30,
	output logic busy,
	output logic signed [33:0] cos_q30,
	output logic signed [33:0] sin_q30
);

	logic [4:0] step_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] xs, ys, at;

	// One shift-and-add rotation per cycle.
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = $signed({4'd0, atan_q30(step_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			step_q <= '0;
		end else if (busy) begin
			if (step_q == 5'(CORDIC_STEPS - 1)) begin
				busy <= 1'b0;
			end
			step_q <= step_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= $signed({2'd0, angle_q30});
		end else if (busy) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_q30 = x_q;
	assign sin_q30 = y_q;

endmodule
`default_nettype wire

>>> src/matrix_stack_transform_engine.sv
// Top level of the matrix stack transform engine: sequencer, shared multiply-accumulate, stack.
//
//  channel | signals                                                   | role
//  in      | in_valid in_ready mode x/y/z_offset angle_deg elem_*      | commands
//  out     | out_valid out_ready out_index out_value status last       | matrix elements
//
// A translation or multiply forms 64 products on the one shared multiplier, each product
// registered and then accumulated, then updates the current matrix and makes 16 output
// transfers; a rotation first adds range folding, the radian product and the 24-step CORDIC.
// Push stores 16 elements with no output; pop loads 16 back and then makes 16 output transfers.
// The block takes no command until the previous one and its transfers are done; a stalled
// output holds the sequencer. Reset gives identity matrices and an empty stack.
`default_nettype none
module matrix_stack_transform_engine
	import mste_pkg::*;
#(
	parameter int STACK_ENTRIES = 32,
	parameter int ELEMENT_BITS = 32,
	parameter int FRACTION_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] mode,
	input wire logic signed [31:0] x_offset,
	input wire logic signed [31:0] y_offset,
	input wire logic signed [31:0] z_offset,
	input wire logic signed [25:0] angle_deg,
	input wire logic [3:0] elem_index,
	input wire logic signed [31:0] elem_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic [3:0] out_index,
	output logic signed [31:0] out_value,
	output logic [1:0] status,
	output logic last
);

	localparam int EB = ELEMENT_BITS;
	localparam int LW = $clog2(STACK_ENTRIES + 1);
	localparam int AW = $clog2(STACK_ENTRIES) + 4;
	localparam int PW = 2 * EB;
	localparam int AC = PW + 3;
	localparam logic signed [EB-1:0] EMAX = {1'b0, {(EB-1){1'b1}}};
	localparam logic signed [EB-1:0] EMIN = {1'b1, {(EB-1){1'b0}}};
	localparam logic signed [EB-1:0] EONE =
		(FRACTION_BITS >= EB - 1) ? EMAX : EB'(64'sd1 <<< FRACTION_BITS);
	localparam int QS = 30 - FRACTION_BITS;

	state_t state_q, state_d;
	logic signed [EB-1:0] cur_q [16];
	logic signed [EB-1:0] opd_q [16];
	logic signed [EB-1:0] bm_q [16];
	logic signed [EB-1:0] bm_init [16];
	logic signed [EB-1:0] res_q [16];
	logic [LW-1:0] level_q;
	logic [5:0] cnt_q;
	logic signed [27:0] deg_q;
	logic sneg_q, cneg_q;
	logic [47:0] rad_prod_s1;
	logic signed [AC-1:0] acc_q;
	logic signed [PW-1:0] prod_s1;
	logic prod_vld_s1, prod_lastk_s1;
	logic [3:0] prod_el_s1;
	logic [1:0] err_q;
	logic signed [EB-1:0] stack_mem [STACK_ENTRIES*16];
	logic signed [EB-1:0] rd_data_q;
	logic cordic_start, cordic_busy;
	logic signed [33:0] cq, sq;
	logic [3:0] emit_sel;

	// Saturation of a wide signed value to the element range.
	function automatic logic signed [EB-1:0] sat_w(input logic signed [AC-1:0] v);
		if (v > AC'(EMAX)) return EMAX;
		if (v < AC'(EMIN)) return EMIN;
		return EB'(v);
	endfunction

	function automatic logic signed [EB-1:0] sat32(input logic signed [31:0] v);
		return sat_w(AC'(v));
	endfunction

	// Saturation of a wide signed value to the 32-bit output range.
	function automatic logic signed [31:0] sat_out(input logic signed [AC-1:0] v);
		if (v > AC'(33'sd2147483647)) return 32'sh7FFFFFFF;
		if (v < AC'(-33'sd2147483648)) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [EB-1:0] q30_elem(input logic signed [33:0] v);
		logic signed [AC-1:0] t;
		t = AC'(v);
		if (QS > 0) t = (t + (AC'(1) <<< (QS - 1))) >>> QS;
		else t = t <<< (-QS);
		return sat_w(t);
	endfunction

	mste_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cordic_start),
		.angle_q30(rad_prod_s1[47:16]),
		.busy(cordic_busy),
		.cos_q30(cq),
		.sin_q30(sq)
	);

	// Right-hand matrix for the command waiting at the input.
	always_comb begin
		for (int i = 0; i < 16; i++) bm_init[i] = (i % 5 == 0) ? EONE : '0;
		case (mode_t'(mode))
			MODE_TRANSLATE: begin
				bm_init[12] = sat32(x_offset);
				bm_init[13] = sat32(y_offset);
				bm_init[14] = sat32(z_offset);
			end
			MODE_MULTIPLY: for (int i = 0; i < 16; i++) bm_init[i] = opd_q[i];
			default: ;
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (mode_t'(mode))
						MODE_IDENTITY, MODE_WRITE_CUR: state_d = ST_EMIT;
						MODE_TRANSLATE, MODE_MULTIPLY: state_d = ST_MAC;
						MODE_ROTATE_Y: state_d = ST_RANGE;
						MODE_PUSH: state_d = (level_q >= LW'(STACK_ENTRIES)) ? ST_ERROR : ST_PUSH;
						MODE_POP: state_d = (level_q == '0) ? ST_ERROR : ST_POP_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RANGE: state_d = ST_RAD;
			ST_RAD: state_d = ST_CORDIC;
			ST_CORDIC: if (!cordic_busy && cnt_q == 6'd2) state_d = ST_TRIG;
			ST_TRIG: state_d = ST_MAC;
			ST_MAC: if (prod_vld_s1 && prod_lastk_s1 && prod_el_s1 == 4'd15) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_EMIT;
			ST_PUSH: if (cnt_q == 6'd15) state_d = ST_IDLE;
			ST_POP_RD: state_d = ST_POP_WR;
			ST_POP_WR: if (cnt_q == 6'd16) state_d = ST_EMIT;
			ST_EMIT: if (out_ready && cnt_q == 6'd15) state_d = ST_IDLE;
			ST_ERROR: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and result outputs.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT) || (state_q == ST_ERROR);
		emit_sel = (state_q == ST_EMIT) ? cnt_q[3:0] : 4'd0;
		out_index = emit_sel;
		out_value = sat_out(AC'(cur_q[emit_sel]));
		status = (state_q == ST_ERROR) ? err_q : STATUS_OK;
		last = (state_q == ST_ERROR) || (cnt_q == 6'd15);
		cordic_start = (state_q == ST_CORDIC) && (cnt_q == 6'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack memory with one write port and one read port, read data registered.
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH) begin
			stack_mem[AW'({level_q, 4'd0}) + AW'(cnt_q[3:0])] <= cur_q[cnt_q[3:0]];
		end
		rd_data_q <= stack_mem[AW'({LW'(level_q - LW'(1)), 4'd0}) + AW'(cnt_q[3:0])];
	end

	// Datapath: counters, operand setup, shared multiply-accumulate and matrix updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				cur_q[i] <= (i % 5 == 0) ? EONE : '0;
				opd_q[i] <= (i % 5 == 0) ? EONE : '0;
			end
			level_q <= '0;
			cnt_q <= '0;
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					acc_q <= '0;
					deg_q <= 28'(angle_deg);
					for (int i = 0; i < 16; i++) bm_q[i] <= bm_init[i];
					if (in_valid) begin
						case (mode_t'(mode))
							MODE_IDENTITY: for (int i = 0; i < 16; i++)
								cur_q[i] <= (i % 5 == 0) ? EONE : '0;
							MODE_WRITE_CUR: cur_q[elem_index] <= sat32(elem_value);
							MODE_WRITE_OPD: opd_q[elem_index] <= sat32(elem_value);
							MODE_PUSH: err_q <= STATUS_OVERFLOW;
							MODE_POP: err_q <= STATUS_UNDERFLOW;
							default: ;
						endcase
					end
				end
				ST_RANGE: begin
					// Wrap into -180..180, then fold to 0..90.
					logic signed [27:0] d;
					logic [27:0] m;
					d = deg_q;
					if (d > DEG180) d = d - DEG360;
					if (d < -DEG180) d = d + DEG360;
					sneg_q <= d[27];
					m = d[27] ? 28'(-d) : 28'(d);
					cneg_q <= (m > 28'(DEG90));
					if (m > 28'(DEG90)) m = 28'(DEG180) - m;
					deg_q <= $signed(m);
				end
				ST_RAD: begin
					rad_prod_s1 <= 48'(deg_q[22:0]) * 48'(RAD_PER_DEG_Q30) + 48'd32768;
					cnt_q <= 6'd1;
				end
				// The rotation unit starts once the radian product is registered.
				ST_CORDIC: if (cnt_q == 6'd1) cnt_q <= 6'd2;
				ST_TRIG: begin
					logic signed [EB-1:0] c, s;
					c = q30_elem(cq);
					s = q30_elem(sq);
					if (cneg_q) c = sat_w(-AC'(c));
					if (sneg_q) s = sat_w(-AC'(s));
					bm_q[0] <= c;
					bm_q[2] <= s;
					bm_q[8] <= sat_w(-AC'(s));
					bm_q[10] <= c;
					cnt_q <= '0;
				end
				ST_MAC: begin
					// cnt = element*4 + k; product registered, then accumulated.
					prod_s1 <= PW'(cur_q[{cnt_q[1:0], cnt_q[3:2]}]) *
						PW'(bm_q[{cnt_q[5:4], cnt_q[1:0]}]);
					prod_vld_s1 <= (cnt_q != 6'd63) || (prod_el_s1 != 4'd15) || !prod_lastk_s1;
					prod_lastk_s1 <= (cnt_q[1:0] == 2'd3);
					prod_el_s1 <= cnt_q[5:2];
					if (cnt_q != 6'd63) cnt_q <= cnt_q + 6'd1;
					if (prod_vld_s1) begin
						if (prod_lastk_s1) begin
							res_q[prod_el_s1] <= sat_w((acc_q + AC'(prod_s1) +
								(AC'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
							acc_q <= '0;
						end else begin
							acc_q <= acc_q + AC'(prod_s1);
						end
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 16; i++) cur_q[i] <= res_q[i];
					cnt_q <= '0;
				end
				ST_PUSH: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) level_q <= level_q + LW'(1);
				end
				ST_POP_RD: cnt_q <= 6'd1;
				ST_POP_WR: begin
					cur_q[4'(cnt_q - 6'd1)] <= rd_data_q;
					if (cnt_q == 6'd16) begin
						level_q <= level_q - LW'(1);
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_EMIT: if (out_ready) cnt_q <= cnt_q + 6'd1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Testbench for the matrix stack transform engine, with a scoreboard that predicts every element.
`default_nettype none
module testbench;
	import mste_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int STACK_SLOTS = 32;

	// Scoreboard: holds its own copy of the matrices and stack and the queue of expected elements.
	class xform_scoreboard;
		typedef struct packed {
			logic [3:0] idx;
			logic [31:0] value;
			logic [1:0] st;
			logic lst;
		} element_rec_t;

		element_rec_t pending_elems[$];
		logic signed [31:0] cur[16];
		logic signed [31:0] opd[16];
		logic signed [31:0] saved[STACK_SLOTS][16];
		int level;
		int mismatches;
		int checked;

		function new();
			for (int i = 0; i < 16; i++) begin
				cur[i] = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
				opd[i] = cur[i];
			end
			level = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function logic signed [31:0] clamp(input longint v);
			if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
			if (v < -64'sh80000000) return 32'sh80000000;
			return v[31:0];
		endfunction

		// Post-multiply the current matrix by b, rounding half up and saturating.
		function void post_multiply(input logic signed [31:0] b[16]);
			logic signed [31:0] c[16];
			logic signed [65:0] acc;
			for (int j = 0; j < 4; j++)
				for (int i = 0; i < 4; i++) begin
					acc = '0;
					for (int k = 0; k < 4; k++)
						acc = acc + $signed(cur[k * 4 + i]) * $signed(b[j * 4 + k]);
					acc = (acc + 66'sd32768) >>> 16;
					if (acc > 66'sh7FFFFFFF) c[j * 4 + i] = 32'sh7FFFFFFF;
					else if (acc < -66'sh80000000) c[j * 4 + i] = 32'sh80000000;
					else c[j * 4 + i] = acc[31:0];
				end
			cur = c;
		endfunction

		// Sine and cosine of an angle in degrees by range folding and a 24-step CORDIC.
		function void sin_cos(input longint deg, output logic signed [31:0] s,
				output logic signed [31:0] c);
			longint m, x, y, z, t;
			bit sneg, cneg;
			cneg = 0;
			if (deg > DEG180) deg -= DEG360;
			if (deg < -DEG180) deg += DEG360;
			sneg = deg < 0;
			m = sneg ? -deg : deg;
			if (m > DEG90) begin
				m = DEG180 - m;
				cneg = 1;
			end
			z = (m * RAD_PER_DEG_Q30 + 32768) >> 16;
			x = CORDIC_GAIN_Q30;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z -= longint'(atan_q30(i[4:0]));
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z += longint'(atan_q30(i[4:0]));
				end
				x = t;
			end
			c = clamp((x + 8192) >>> 14);
			s = clamp((y + 8192) >>> 14);
			if (cneg) c = clamp(-longint'(c));
			if (sneg) s = clamp(-longint'(s));
		endfunction

		function void expect_matrix();
			for (int i = 0; i < 16; i++)
				pending_elems.push_back({i[3:0], cur[i], STATUS_OK, 1'(i == 15)});
		endfunction

		// Note one accepted command and queue the elements it should produce.
		function void note_command(input mode_t md, input logic signed [31:0] xo, yo, zo,
				input logic signed [25:0] ang, input logic [3:0] ei,
				input logic signed [31:0] ev);
			logic signed [31:0] t[16];
			logic signed [31:0] s, c;
			for (int i = 0; i < 16; i++) t[i] = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
			case (md)
				MODE_IDENTITY: begin
					cur = t;
					expect_matrix();
				end
				MODE_TRANSLATE: begin
					t[12] = xo;
					t[13] = yo;
					t[14] = zo;
					post_multiply(t);
					expect_matrix();
				end
				MODE_ROTATE_Y: begin
					sin_cos(longint'(ang), s, c);
					t[0] = c;
					t[2] = s;
					t[8] = clamp(-longint'(s));
					t[10] = c;
					post_multiply(t);
					expect_matrix();
				end
				MODE_PUSH: begin
					if (level >= STACK_SLOTS)
						pending_elems.push_back({4'd0, cur[0], STATUS_OVERFLOW, 1'b1});
					else begin
						saved[level] = cur;
						level++;
					end
				end
				MODE_POP: begin
					if (level == 0)
						pending_elems.push_back({4'd0, cur[0], STATUS_UNDERFLOW, 1'b1});
					else begin
						level--;
						cur = saved[level];
						expect_matrix();
					end
				end
				MODE_WRITE_CUR: begin
					cur[ei] = ev;
					expect_matrix();
				end
				MODE_WRITE_OPD: opd[ei] = ev;
				default: begin
					post_multiply(opd);
					expect_matrix();
				end
			endcase
		endfunction

		function void report(input string what);
			mismatches++;
			if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, what);
		endfunction

		// Compare one output transfer with the oldest expected element.
		function void check_result(input logic [3:0] idx, input logic [31:0] value,
				input logic [1:0] st, input logic lst);
			element_rec_t e;
			checked++;
			if (pending_elems.size() == 0) begin
				report($sformatf("unexpected element idx=%0d value=%h status=%0d last=%0b",
					idx, value, st, lst));
				return;
			end
			e = pending_elems.pop_front();
			if (idx !== e.idx)
				report($sformatf("out_index expected %0d actual %0d", e.idx, idx));
			if (value !== e.value)
				report($sformatf("out_value[%0d] expected %h actual %h", e.idx, e.value, value));
			if (st !== e.st)
				report($sformatf("status expected %0d actual %0d", e.st, st));
			if (lst !== e.lst)
				report($sformatf("last expected %0b actual %0b", e.lst, lst));
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [2:0] mode;
	logic signed [31:0] x_offset, y_offset, z_offset, elem_value;
	logic signed [25:0] angle_deg;
	logic [3:0] elem_index;
	logic out_valid, out_ready;
	logic [3:0] out_index;
	logic signed [31:0] out_value;
	logic [1:0] status;
	logic last;

	xform_scoreboard sb;
	int burst_left;
	int cycle_count;
	int rx_count;
	int mode_count[8];

	matrix_stack_transform_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .x_offset(x_offset), .y_offset(y_offset), .z_offset(z_offset),
		.angle_deg(angle_deg), .elem_index(elem_index), .elem_value(elem_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_index(out_index), .out_value(out_value), .status(status), .last(last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls: two fixed patterns, a random phase and a phase with no stall at all.
	initial out_ready = 1'b0;
	always @(negedge clk) begin
		rx_count++;
		case (rx_count[10:9])
			2'd0: out_ready = 1'b1;
			2'd1: out_ready = !(rx_count[2:0] == 3'd5 || rx_count[4:1] == 4'hB);
			2'd2: out_ready = ($urandom_range(0, 3) != 0);
			default: out_ready = (rx_count[5:3] != 3'd2);
		endcase
	end

	// Every output transfer is checked at the rising edge.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_index, out_value, status, last);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Drive one command in bursts, waiting for its transfer, then tell the scoreboard.
	task automatic send_cmd(input mode_t md, input logic [31:0] xo, yo, zo,
			input logic [25:0] ang, input logic [3:0] ei, input logic [31:0] ev);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		mode = md;
		x_offset = xo;
		y_offset = yo;
		z_offset = zo;
		angle_deg = ang;
		elem_index = ei;
		elem_value = ev;
		in_valid = 1'b1;
		burst_left--;
		do @(posedge clk); while (!in_ready);
		sb.note_command(md, xo, yo, zo, ang, ei, ev);
		mode_count[md]++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 32'h20000)) - 32'sh10000);
			default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
		endcase
	endfunction

	function automatic logic [25:0] pick_angle();
		return 26'($signed($urandom_range(0, 47185920)) - 32'sd23592960);
	endfunction

	task automatic send_random(input mode_t md);
		send_cmd(md, pick_value(), pick_value(), pick_value(), pick_angle(),
			4'($urandom_range(0, 15)), pick_value());
	endtask

	initial begin
		mode_t md;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_IDENTITY;
		x_offset = '0;
		y_offset = '0;
		z_offset = '0;
		angle_deg = '0;
		elem_index = '0;
		elem_value = '0;
		burst_left = 0;
		cycle_count = 0;
		rx_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-stack pop, extreme offsets, angle boundaries, extreme writes.
		send_cmd(MODE_POP, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_IDENTITY, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_TRANSLATE, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0, 0, 0);
		send_cmd(MODE_IDENTITY, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, 26'sd0, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, 26'sd5898240, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, -26'sd5898240, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, 26'sd11796480, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, -26'sd11796480, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, 26'sd23592960, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, -26'sd23592960, 0, 0);
		send_cmd(MODE_ROTATE_Y, 0, 0, 0, 26'sd2981888, 0, 0);
		send_cmd(MODE_WRITE_CUR, 0, 0, 0, 0, 4'd0, 32'h7FFFFFFF);
		send_cmd(MODE_WRITE_CUR, 0, 0, 0, 0, 4'd15, 32'h80000000);
		send_cmd(MODE_PUSH, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_WRITE_OPD, 0, 0, 0, 0, 4'd15, 32'h80000000);
		send_cmd(MODE_WRITE_OPD, 0, 0, 0, 0, 4'd3, 32'h7FFFFFFF);
		send_cmd(MODE_MULTIPLY, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_POP, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_IDENTITY, 0, 0, 0, 0, 0, 0);
		send_cmd(MODE_WRITE_OPD, 0, 0, 0, 0, 4'd12, 32'h00020000);
		send_cmd(MODE_MULTIPLY, 0, 0, 0, 0, 0, 0);

		// Fill the stack past full and drain it past empty, with random edits in between.
		for (int i = 0; i < 34; i++) begin
			send_cmd(MODE_PUSH, 0, 0, 0, 0, 0, 0);
			if (i % 8 == 3) send_random(MODE_ROTATE_Y);
		end
		for (int i = 0; i < 34; i++) begin
			send_cmd(MODE_POP, 0, 0, 0, 0, 0, 0);
			if (i % 8 == 5) send_random(MODE_WRITE_CUR);
		end

		// Random commands, with pushes and pops equally likely.
		for (int n = 0; n < 110; n++) begin
			md = mode_t'($urandom_range(0, 7));
			send_random(md);
		end

		// Stop offering commands, then let the outstanding elements drain.
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_elems.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d identity, %0d translate, %0d rotate, %0d push, %0d pop commands,",
			mode_count[0], mode_count[1], mode_count[2], mode_count[3], mode_count[4]);
		$display("%0d element writes, %0d multiplies; %0d output transfers, %0d mismatches.",
			mode_count[5] + mode_count[6], mode_count[7], sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
